// File: rtl/sccb16_pkg.sv
// shared types and constants of the sccb master with 16-bit register addresses
// no dependencies; used by the top level and the bus sequencer
package sccb16_pkg;

    // command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_BURST = 2'd3;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_PERIOD    = 1'b1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd120;
    localparam logic [15:0] HALF_PERIOD_RESET    = 16'd250;
    localparam logic [7:0]  READ_BIT             = 8'h01;

    // one tick of bus input
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] reg_address;
        logic [7:0]  write_byte;
        logic        byte_valid;
        logic [15:0] burst_length;
        logic        sda_in;
    } item_t;

    // one tick of bus output
    typedef struct packed {
        logic [7:0] read_value;
        logic       status;
        logic       done_res;
        logic       byte_request;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } result_t;

endpackage

// File: rtl/sccb16_seq.sv
// bus sequencer: phase register, delay counter, shifter and transfer bookkeeping
// depends on sccb16_pkg; advances one tick per accepted request
module sccb16_seq #(
    parameter int BURST_COUNT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  sccb16_pkg::item_t    item,
    input  logic [7:0]           device_address,
    input  logic [15:0]          half_period,
    output sccb16_pkg::result_t  result
);

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_START1  = 5'd1;
    localparam logic [4:0] PH_START2  = 5'd2;
    localparam logic [4:0] PH_START3  = 5'd3;
    localparam logic [4:0] PH_WSETUP  = 5'd4;
    localparam logic [4:0] PH_WHIGH   = 5'd5;
    localparam logic [4:0] PH_ACKREL  = 5'd6;
    localparam logic [4:0] PH_ACKHIGH = 5'd7;
    localparam logic [4:0] PH_ACKLOW  = 5'd8;
    localparam logic [4:0] PH_STOP1   = 5'd9;
    localparam logic [4:0] PH_STOP2   = 5'd10;
    localparam logic [4:0] PH_STOP3   = 5'd11;
    localparam logic [4:0] PH_STOP4   = 5'd12;
    localparam logic [4:0] PH_GAP     = 5'd13;
    localparam logic [4:0] PH_RHIGH   = 5'd14;
    localparam logic [4:0] PH_RLOW    = 5'd15;
    localparam logic [4:0] PH_NACK1   = 5'd16;
    localparam logic [4:0] PH_NACK2   = 5'd17;
    localparam logic [4:0] PH_NACK3   = 5'd18;
    localparam logic [4:0] PH_WAITB   = 5'd19;

    logic [4:0]                  phase_reg, phase_next;
    logic [15:0]                 tick_reg, tick_next;
    logic [7:0]                  shift_reg, shift_next;
    logic [3:0]                  bit_reg, bit_next;
    logic [BURST_COUNT_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [15:0]                 held_address_reg, held_address_next;
    logic [1:0]                  held_command_reg, held_command_next;
    logic [7:0]                  held_value_reg, held_value_next;
    logic [1:0]                  stage_reg, stage_next;
    logic                        second_reg, second_next;
    logic                        failed_reg, failed_next;
    logic                        scl_reg, scl_next;
    logic                        sda_reg, sda_next;

    logic [15:0] hp;
    logic [15:0] tick_inc;
    logic [4:0]  bit_inc;
    logic [31:0] blen_wide;
    logic        go_en;
    logic [4:0]  go_phase;
    logic        done, stat;
    logic [7:0]  rval;

    assign hp        = (half_period == 16'd0) ? 16'd1 : half_period;
    assign tick_inc  = tick_reg + 16'd1;
    assign bit_inc   = {1'b0, bit_reg} + 5'd1;
    assign blen_wide = {16'd0, item.burst_length};

    always_comb begin
        phase_next        = phase_reg;
        tick_next         = tick_reg;
        shift_next        = shift_reg;
        bit_next          = bit_reg;
        bytes_left_next   = bytes_left_reg;
        held_address_next = held_address_reg;
        held_command_next = held_command_reg;
        held_value_next   = held_value_reg;
        stage_next        = stage_reg;
        second_next       = second_reg;
        failed_next       = failed_reg;
        scl_next          = scl_reg;
        sda_next          = sda_reg;
        go_en             = 1'b0;
        go_phase          = phase_reg;
        done              = 1'b0;
        stat              = 1'b0;
        rval              = 8'd0;

        if (phase_reg == PH_IDLE) begin
            if (item.cmd != sccb16_pkg::CMD_NONE) begin
                held_command_next = item.cmd;
                held_address_next = item.reg_address;
                held_value_next   = item.write_byte;
                bytes_left_next   = blen_wide[BURST_COUNT_BITS-1:0];
                stage_next        = 2'd0;
                second_next       = 1'b0;
                failed_next       = 1'b0;
                go_en             = 1'b1;
                go_phase          = PH_START1;
            end
        end else if (phase_reg == PH_WAITB) begin
            if (item.byte_valid) begin
                bytes_left_next = bytes_left_reg - BURST_COUNT_BITS'(1);
                shift_next      = item.write_byte;
                bit_next        = 4'd0;
                go_en           = 1'b1;
                go_phase        = PH_WSETUP;
            end
        end else begin
            tick_next = tick_inc;
            if (tick_inc >= hp) begin
                go_en = 1'b1;
                case (phase_reg)
                    PH_START1: go_phase = PH_START2;
                    PH_START2: go_phase = PH_START3;
                    PH_START3: begin
                        stage_next = 2'd0;
                        shift_next = second_reg ? (device_address | sccb16_pkg::READ_BIT)
                                                : device_address;
                        bit_next   = 4'd0;
                        go_phase   = PH_WSETUP;
                    end
                    PH_WSETUP: go_phase = PH_WHIGH;
                    PH_WHIGH: begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next   = bit_inc[3:0];
                        go_phase   = (bit_inc < 5'd8) ? PH_WSETUP : PH_ACKREL;
                    end
                    PH_ACKREL: go_phase = PH_ACKHIGH;
                    PH_ACKHIGH: begin
                        if (item.sda_in) begin
                            failed_next = 1'b1;
                        end
                        go_phase = PH_ACKLOW;
                    end
                    PH_ACKLOW: begin
                        // next byte of the transfer, or stop
                        if (failed_reg) begin
                            go_phase = PH_STOP1;
                        end else if (stage_reg == 2'd0 && second_reg) begin
                            shift_next = 8'd0;
                            bit_next   = 4'd0;
                            go_phase   = PH_RHIGH;
                        end else if (stage_reg == 2'd0) begin
                            stage_next = 2'd1;
                            shift_next = held_address_reg[15:8];
                            bit_next   = 4'd0;
                            go_phase   = PH_WSETUP;
                        end else if (stage_reg == 2'd1) begin
                            stage_next = 2'd2;
                            shift_next = held_address_reg[7:0];
                            bit_next   = 4'd0;
                            go_phase   = PH_WSETUP;
                        end else if (held_command_reg == sccb16_pkg::CMD_WRITE
                                     && stage_reg == 2'd2) begin
                            stage_next = 2'd3;
                            shift_next = held_value_reg;
                            bit_next   = 4'd0;
                            go_phase   = PH_WSETUP;
                        end else if (held_command_reg == sccb16_pkg::CMD_BURST) begin
                            stage_next = 2'd3;
                            go_phase   = (bytes_left_reg == '0) ? PH_STOP1 : PH_WAITB;
                        end else begin
                            go_phase = PH_STOP1;
                        end
                    end
                    PH_STOP1: go_phase = PH_STOP2;
                    PH_STOP2: go_phase = PH_STOP3;
                    PH_STOP3: go_phase = PH_STOP4;
                    PH_STOP4: begin
                        if (held_command_reg == sccb16_pkg::CMD_READ && !second_reg
                            && !failed_reg) begin
                            second_next = 1'b1;
                            go_phase    = PH_GAP;
                        end else begin
                            done     = 1'b1;
                            stat     = failed_reg;
                            rval     = (held_command_reg == sccb16_pkg::CMD_READ
                                        && !failed_reg) ? held_value_reg : 8'd0;
                            go_phase = PH_IDLE;
                        end
                    end
                    PH_GAP: go_phase = PH_START1;
                    PH_RHIGH: begin
                        shift_next = {shift_reg[6:0], item.sda_in};
                        go_phase   = PH_RLOW;
                    end
                    PH_RLOW: begin
                        bit_next = bit_inc[3:0];
                        if (bit_inc < 5'd8) begin
                            go_phase = PH_RHIGH;
                        end else begin
                            held_value_next = shift_reg;
                            go_phase        = PH_NACK1;
                        end
                    end
                    PH_NACK1: go_phase = PH_NACK2;
                    PH_NACK2: go_phase = PH_NACK3;
                    PH_NACK3: go_phase = PH_STOP1;
                    default:  go_phase = PH_IDLE;
                endcase
            end
        end

        // entering a phase restarts the delay and sets the line levels
        if (go_en) begin
            phase_next = go_phase;
            tick_next  = 16'd0;
            case (go_phase)
                PH_START1:  begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_START2:  sda_next = 1'b0;
                PH_START3:  scl_next = 1'b0;
                PH_WSETUP:  begin scl_next = 1'b0; sda_next = shift_next[7]; end
                PH_WHIGH:   scl_next = 1'b1;
                PH_ACKREL:  begin scl_next = 1'b0; sda_next = 1'b1; end
                PH_ACKHIGH: scl_next = 1'b1;
                PH_ACKLOW:  scl_next = 1'b0;
                PH_STOP1:   scl_next = 1'b0;
                PH_STOP2:   sda_next = 1'b0;
                PH_STOP3:   scl_next = 1'b1;
                PH_STOP4:   sda_next = 1'b1;
                PH_RHIGH:   begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_RLOW:    scl_next = 1'b0;
                PH_NACK1:   sda_next = 1'b1;
                PH_NACK2:   scl_next = 1'b1;
                PH_NACK3:   scl_next = 1'b0;
                PH_IDLE:    begin scl_next = 1'b1; sda_next = 1'b1; end
                default:    ;
            endcase
        end
    end

    always_comb begin
        result.scl_out      = scl_reg;
        result.sda_out      = sda_reg;
        result.busy_res     = (phase_reg != PH_IDLE) || (item.cmd != sccb16_pkg::CMD_NONE);
        result.byte_request = (phase_reg == PH_WAITB);
        result.done_res     = done;
        result.status       = stat;
        result.read_value   = rval;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            tick_reg         <= 16'd0;
            shift_reg        <= 8'd0;
            bit_reg          <= 4'd0;
            bytes_left_reg   <= '0;
            held_address_reg <= 16'd0;
            held_command_reg <= sccb16_pkg::CMD_NONE;
            held_value_reg   <= 8'd0;
            stage_reg        <= 2'd0;
            second_reg       <= 1'b0;
            failed_reg       <= 1'b0;
            scl_reg          <= 1'b1;
            sda_reg          <= 1'b1;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            tick_reg         <= tick_next;
            shift_reg        <= shift_next;
            bit_reg          <= bit_next;
            bytes_left_reg   <= bytes_left_next;
            held_address_reg <= held_address_next;
            held_command_reg <= held_command_next;
            held_value_reg   <= held_value_next;
            stage_reg        <= stage_next;
            second_reg       <= second_next;
            failed_reg       <= failed_next;
            scl_reg          <= scl_next;
            sda_reg          <= sda_next;
        end
    end

endmodule

// File: rtl/sccb_master_16bit_register_access.sv
// top level of the sccb master with 16-bit register addresses
// depends on sccb16_pkg and sccb16_seq; holds configuration and the result register
//
// Each request on the s_ side is one tick of the bus sequencer and gives exactly one
// result on the m_ side from the output register. A request is taken in every cycle, also
// while the previous result sits in the output register and is taken at the same
// edge; the only limit is that output register, so the block stalls only while
// m_tready is low. Line timing counts requests, not clocks: every step between pin
// changes lasts half_period requests (one if it is zero). Configuration writes land at once.
module sccb_master_16bit_register_access #(
    parameter int BURST_COUNT_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // reg_address[15:0], write_byte[23:16], burst_length[39:24], sda_in[40], zeros
    input  logic [47:0]                           s_tdata,
    // cmd[1:0], byte_valid[2]
    input  logic [2:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // scl_out[0], sda_out[1], busy_res[2], byte_request[3], done_res[4],
    // status[5], read_value[13:6], zeros
    output logic [15:0]                           m_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [sccb16_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sccb16_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data
);

    logic                accept;
    sccb16_pkg::item_t   item;
    sccb16_pkg::result_t result;
    logic [7:0]          device_address_reg;
    logic [15:0]         half_period_reg;
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign item.cmd          = s_tuser[1:0];
    assign item.byte_valid   = s_tuser[2];
    assign item.reg_address  = s_tdata[15:0];
    assign item.write_byte   = s_tdata[23:16];
    assign item.burst_length = s_tdata[39:24];
    assign item.sda_in       = s_tdata[40];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= sccb16_pkg::DEVICE_ADDRESS_RESET;
            half_period_reg    <= sccb16_pkg::HALF_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sccb16_pkg::REG_DEVICE_ADDRESS: device_address_reg <= cfg_wr_data[7:0];
                sccb16_pkg::REG_HALF_PERIOD:    half_period_reg    <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    sccb16_seq #(
        .BURST_COUNT_BITS(BURST_COUNT_BITS)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (accept),
        .item           (item),
        .device_address (device_address_reg),
        .half_period    (half_period_reg),
        .result         (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {2'b00, result.read_value, result.status, result.done_res,
                            result.byte_request, result.busy_res, result.sda_out,
                            result.scl_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/sccb16_checker.sv
// port-level checks of the sccb master result stream
// depends on the top level's ports; bound to sccb_master_16bit_register_access
module sccb16_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a finished transfer is reported while still marked busy
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[2])
        else $error("done without busy");

    // error status and read data only appear with done
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[5] || (m_tdata[13:6] != 8'd0)) |-> m_tdata[4])
        else $error("status or read value outside done");

    // an aborted transfer never returns read data
    a_abort_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> (m_tdata[13:6] == 8'd0))
        else $error("read value after missing acknowledge");

    // a burst byte request only happens inside a transfer
    a_request_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2] && !m_tdata[4])
        else $error("byte request outside transfer");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind sccb_master_16bit_register_access sccb16_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
